// File: rtl/nabh_pkg.sv
// shared constants and controller/datapath interface types for the name arity bucket hash
`default_nettype none
package nabh_pkg;

    localparam int OUTER_ROUNDS     = 10;
    localparam int GROUP_LEN        = 5;
    localparam int GROUPS_PER_ROUND = 5;
    localparam int TOP_SHIFT        = 4;
    localparam int CHAR_LIMIT       = GROUP_LEN * GROUPS_PER_ROUND * OUTER_ROUNDS;

    localparam int CHAR_W  = 8;
    localparam int ARITY_W = 8;
    localparam int SIZE_W  = 32;
    localparam int SUM_W   = 64;

    localparam int POS_W   = $clog2(CHAR_LIMIT + 1);
    localparam int GIN_W   = $clog2(GROUP_LEN);
    localparam int GRP_W   = $clog2(GROUPS_PER_ROUND);
    localparam int SHIFT_W = $clog2(TOP_SHIFT + 1);
    localparam int DCNT_W  = $clog2(SUM_W);

    localparam int IN_W  = ((CHAR_W + ARITY_W + SIZE_W + 7) / 8) * 8;
    localparam int OUT_W = SIZE_W;

    typedef struct packed {
        logic char_en;   // counted or ignored non-zero character
        logic term_en;   // terminator transfer
        logic fold_grp;  // add partial group into sum
        logic fold_ari;  // add arity into sum, arm divider
        logic div_step;  // one restoring division step
        logic load_out;  // move remainder to output register
    } nabh_cmd_t;

    typedef struct packed {
        logic is_term;
        logic div_last;
        logic out_busy;
    } nabh_sts_t;

endpackage
`default_nettype wire

// File: rtl/nabh_ctrl.sv
// controller state machine sequencing accumulate, fold, divide and result hand-off
`default_nettype none
module nabh_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire nabh_pkg::nabh_sts_t sts,
    output nabh_pkg::nabh_cmd_t     cmd
);
    import nabh_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_FOLD_GRP,
        ST_FOLD_ARI,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_ACCUM);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (accept)
                begin
                    if (sts.is_term)
                    begin
                        cmd.term_en = 1'b1;
                        state_next  = ST_FOLD_GRP;
                    end
                    else
                    begin
                        cmd.char_en = 1'b1;
                    end
                end
            end
            ST_FOLD_GRP:
            begin
                cmd.fold_grp = 1'b1;
                state_next   = ST_FOLD_ARI;
            end
            ST_FOLD_ARI:
            begin
                cmd.fold_ari = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait until the previous result has been taken
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACCUM;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: rtl/nabh_dp.sv
// datapath: group shift-add, running sum, bit-serial modulo and output register
`default_nettype none
module nabh_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [nabh_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [nabh_pkg::OUT_W-1:0]      m_tdata,
    input  wire nabh_pkg::nabh_cmd_t        cmd,
    output nabh_pkg::nabh_sts_t             sts
);
    import nabh_pkg::*;

    logic [CHAR_W-1:0]  in_char;
    logic [ARITY_W-1:0] in_arity;
    logic [SIZE_W-1:0]  in_size;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [GIN_W-1:0]   gin_reg, gin_next;
    logic [GRP_W-1:0]   grp_reg, grp_next;
    logic [SUM_W-1:0]   gv_reg, gv_next;
    logic [SUM_W-1:0]   pend_reg, pend_next;
    logic               pend_v_reg, pend_v_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [ARITY_W-1:0] arity_reg, arity_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [SIZE_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic               out_v_reg, out_v_next;
    logic [OUT_W-1:0]   out_reg, out_next;

    logic [SHIFT_W-1:0] shift;
    logic [SUM_W-1:0]   char_ext;
    logic [SUM_W-1:0]   gv_shadd;
    logic [SIZE_W:0]    rem_sh;
    logic [SIZE_W:0]    rem_sub;

    assign in_char  = s_tdata[CHAR_W-1:0];
    assign in_arity = s_tdata[CHAR_W+ARITY_W-1:CHAR_W];
    assign in_size  = s_tdata[CHAR_W+ARITY_W+SIZE_W-1:CHAR_W+ARITY_W];

    assign shift    = SHIFT_W'(TOP_SHIFT) - SHIFT_W'(grp_reg);
    assign char_ext = {{(SUM_W-CHAR_W){in_char[CHAR_W-1]}}, in_char};
    assign gv_shadd = (gv_reg << shift) + char_ext;

    assign rem_sh  = {rem_reg, sum_reg[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, size_reg};

    assign sts.is_term  = (in_char == '0);
    assign sts.div_last = (dcnt_reg == DCNT_W'(SUM_W - 1));
    assign sts.out_busy = out_v_reg;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        gin_next    = gin_reg;
        grp_next    = grp_reg;
        gv_next     = gv_reg;
        pend_next   = pend_reg;
        pend_v_next = 1'b0;
        sum_next    = sum_reg;
        arity_next  = arity_reg;
        size_next   = size_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        out_v_next  = out_v_reg && !m_tready;
        out_next    = out_reg;

        // completed group is held in pend_reg and lands in the sum in the following cycle
        if (pend_v_reg)
            sum_next = sum_reg + pend_reg;

        if (cmd.char_en && (pos_reg < POS_W'(CHAR_LIMIT)))
        begin
            pos_next = pos_reg + 1'b1;
            if (gin_reg == GIN_W'(GROUP_LEN - 1))
            begin
                pend_next   = gv_shadd;
                pend_v_next = 1'b1;
                gv_next     = '0;
                gin_next    = '0;
                grp_next    = (grp_reg == GRP_W'(GROUPS_PER_ROUND - 1)) ? '0 : grp_reg + 1'b1;
            end
            else
            begin
                gv_next  = gv_shadd;
                gin_next = gin_reg + 1'b1;
            end
        end

        if (cmd.term_en)
        begin
            pos_next   = '0;
            gin_next   = '0;
            grp_next   = '0;
            arity_next = in_arity;
            size_next  = in_size;
        end

        if (cmd.fold_grp)
        begin
            sum_next = sum_reg + gv_reg;
            gv_next  = '0;
        end

        if (cmd.fold_ari)
        begin
            sum_next  = sum_reg + {{(SUM_W-ARITY_W){1'b0}}, arity_reg};
            rem_next  = '0;
            dcnt_next = '0;
        end

        // dividend shifts out of the sum register, leaving it cleared
        if (cmd.div_step)
        begin
            sum_next  = sum_reg << 1;
            rem_next  = (rem_sh >= {1'b0, size_reg}) ? rem_sub[SIZE_W-1:0]
                                                     : rem_sh[SIZE_W-1:0];
            dcnt_next = dcnt_reg + 1'b1;
        end

        if (cmd.load_out)
        begin
            out_v_next = 1'b1;
            out_next   = (size_reg == '0) ? '0 : rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            gin_reg    <= '0;
            grp_reg    <= '0;
            gv_reg     <= '0;
            pend_v_reg <= 1'b0;
            sum_reg    <= '0;
            dcnt_reg   <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            gin_reg    <= gin_next;
            grp_reg    <= grp_next;
            gv_reg     <= gv_next;
            pend_v_reg <= pend_v_next;
            sum_reg    <= sum_next;
            dcnt_reg   <= dcnt_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        arity_reg <= arity_next;
        size_reg  <= size_next;
        rem_reg   <= rem_next;
        out_reg   <= out_next;
    end

endmodule
`default_nettype wire

// File: rtl/name_arity_bucket_hash_core.sv
// top level of the name arity bucket hash: controller plus datapath
// characters: one transfer per cycle, each is folded into the group value in its own cycle
// terminator: group fold, arity fold, then the bit-serial restoring divider over the sum, then
// the output register load, which waits until the previous bucket has been taken
// the input stalls from terminator until the result is loaded into the output register
// reset (rst_n low, asynchronous) clears counters, group value, sum and output valid
`default_nettype none
module name_arity_bucket_hash_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [nabh_pkg::IN_W-1:0]  s_tdata,   // char_code, arity, table_size
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [nabh_pkg::OUT_W-1:0]      m_tdata    // bucket
);
    import nabh_pkg::*;

    nabh_cmd_t cmd;
    nabh_sts_t sts;

    nabh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nabh_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
`default_nettype wire

// File: rtl/nabh_checker.sv
// port-level checks for the name arity bucket hash core
`default_nettype none
module nabh_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [nabh_pkg::IN_W-1:0]  s_tdata,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [nabh_pkg::OUT_W-1:0] m_tdata
);
    import nabh_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // characters stream without a bubble
    a_char_stream: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[CHAR_W-1:0] != '0) |=> s_tready)
        else $error("input stalled after a character");

    // terminator starts the busy period
    a_term_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[CHAR_W-1:0] == '0) |=> !s_tready)
        else $error("input not stalled after terminator");

    // a new result only follows a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without division");

endmodule

bind name_arity_bucket_hash_core nabh_checker u_nabh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the name arity bucket hash core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nabh_pkg::*;

    localparam logic [7:0] NAME_END    = 8'h00;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         ITEM_GOAL   = 1850;
    localparam int         LONG_HOLD   = 400;
    localparam int         TAIL_CYCLES = 100;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;   // char_code, arity, table_size
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;         // bucket

    name_arity_bucket_hash_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    typedef struct packed {
        logic [7:0]  ch;
        logic [7:0]  ar;
        logic [31:0] sz;
        logic        known;
        logic [31:0] bkt;
    } stim_row_t;

    // known = 1 rows carry a bucket read straight off the hash definition
    stim_row_t dir_rows [0:18] = '{
        '{NAME_END, 8'd0,   32'd1,          1'b1, 32'd0},    // empty name after reset
        '{NAME_END, 8'd255, 32'hFFFF_FFFF,  1'b1, 32'd255},
        '{NAME_END, 8'd200, 32'd0,          1'b1, 32'd0},    // zero table size
        '{NAME_END, 8'd255, 32'd16,         1'b1, 32'd15},
        '{8'h80,    8'd255, 32'hFFFF_FFFF,  1'b0, 32'd0},
        '{NAME_END, 8'd0,   32'hFFFF_FFFF,  1'b0, 32'd0},
        '{8'h7F,    8'd0,   32'd0,          1'b0, 32'd0},
        '{NAME_END, 8'd0,   32'd1000,       1'b1, 32'd127},
        '{8'h01,    8'd17,  32'd3,          1'b0, 32'd0},
        '{8'h01,    8'd0,   32'd0,          1'b0, 32'd0},
        '{8'h01,    8'd255, 32'hFFFF_FFFF,  1'b0, 32'd0},
        '{8'h01,    8'd1,   32'd1,          1'b0, 32'd0},
        '{8'h01,    8'd128, 32'h8000_0000,  1'b0, 32'd0},
        '{NAME_END, 8'd0,   32'hFFFF_FFFF,  1'b0, 32'd0},    // end right after a full group
        '{8'hFF,    8'd0,   32'd0,          1'b0, 32'd0},
        '{8'hFF,    8'd0,   32'd0,          1'b0, 32'd0},
        '{NAME_END, 8'd255, 32'd7,          1'b0, 32'd0},
        '{8'h05,    8'd0,   32'd0,          1'b0, 32'd0},
        '{NAME_END, 8'd9,   32'd0,          1'b1, 32'd0}     // zero size on a real name
    };

    // predictor state
    int          name_pos;
    logic [63:0] grp_val;
    logic [63:0] hash_sum;

    logic [31:0] expected_buckets [$];
    int          mismatch_count;
    int          cycle_count;
    bit          send_idle;
    bit          recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // folds one accepted item into the name hash; emits a bucket on the terminator
    function automatic void hash_name_item(input logic [7:0] ch, input logic [7:0] ar,
                                           input logic [31:0] sz, output bit emit,
                                           output logic [31:0] bkt);
        int          shift;
        logic [63:0] total;
        emit = 1'b0;
        bkt  = '0;
        if (ch != NAME_END)
        begin
            if (name_pos < CHAR_LIMIT)
            begin
                shift    = TOP_SHIFT - ((name_pos / GROUP_LEN) % GROUPS_PER_ROUND);
                grp_val  = (grp_val << shift) + {{56{ch[7]}}, ch};
                name_pos = name_pos + 1;
                if (name_pos % GROUP_LEN == 0)
                begin
                    hash_sum = hash_sum + grp_val;
                    grp_val  = '0;
                end
            end
        end
        else
        begin
            total    = hash_sum + grp_val + {56'd0, ar};
            bkt      = (sz != 0) ? 32'(total % {32'd0, sz}) : 32'd0;
            emit     = 1'b1;
            name_pos = 0;
            grp_val  = '0;
            hash_sum = '0;
        end
    endfunction

    task automatic offer_item(input logic [7:0] ch, input logic [7:0] ar, input logic [31:0] sz,
                              input logic known, input logic [31:0] known_bkt);
        int          gap;
        bit          emit;
        logic [31:0] bkt;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sz, ar, ch};
        do @(posedge clk); while (!s_tready);
        hash_name_item(ch, ar, sz, emit, bkt);
        if (emit)
            expected_buckets.push_back(known ? known_bkt : bkt);
    endtask

    task automatic drain_buckets();
        s_tvalid <= 1'b0;
        while (expected_buckets.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'hFF;
            3:       return 8'h01;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(1, 16));
            3:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls, two long hold-offs so the input backs up
    initial
    begin
        int stall;
        int got;
        got       = 0;
        recv_idle = 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (got == 12 || got == 40)
                stall = LONG_HOLD;
            else
                stall = recv_idle ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got++;
            if (expected_buckets.size() == 0)
                report_mismatch($sformatf("unexpected bucket %0d", m_tdata));
            else if (m_tdata !== expected_buckets[0])
            begin
                report_mismatch($sformatf("bucket %0d, expected %0d",
                                          m_tdata, expected_buckets[0]));
                void'(expected_buckets.pop_front());
            end
            else
                void'(expected_buckets.pop_front());
            if ($urandom_range(0, 15) == 0)
                recv_idle = !recv_idle;
        end
    end

    initial
    begin
        int counted;
        int len;
        int r;
        name_pos       = 0;
        grp_val        = '0;
        hash_sum       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle      = 1'b1;
        counted        = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        for (int i = 0; i < $size(dir_rows); i++)
            offer_item(dir_rows[i].ch, dir_rows[i].ar, dir_rows[i].sz,
                       dir_rows[i].known, dir_rows[i].bkt);
        drain_buckets();

        while (counted < ITEM_GOAL)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                len = $urandom_range(0, 12);
            else if (r < 96)
                len = $urandom_range(13, 60);
            else
            begin
                // names around and past the character limit
                case ($urandom_range(0, 3))
                    0:       len = CHAR_LIMIT - 1;
                    1:       len = CHAR_LIMIT;
                    2:       len = CHAR_LIMIT + 1;
                    default: len = $urandom_range(CHAR_LIMIT + 2, CHAR_LIMIT + 50);
                endcase
            end
            for (int k = 0; k < len; k++)
                offer_item(pick_char(), 8'($urandom_range(0, 255)), $urandom, 1'b0, '0);
            offer_item(NAME_END, 8'($urandom_range(0, 255)), pick_size(), 1'b0, '0);
            counted += ((len < CHAR_LIMIT) ? len : CHAR_LIMIT) + 1;
            if ($urandom_range(0, 7) == 0)
                send_idle = !send_idle;
            if ($urandom_range(0, 14) == 0)
                drain_buckets();
        end

        s_tvalid <= 1'b0;
        while (expected_buckets.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: name_arity_bucket_hash_core.f
rtl/nabh_pkg.sv
rtl/nabh_ctrl.sv
rtl/nabh_dp.sv
rtl/name_arity_bucket_hash_core.sv
rtl/nabh_checker.sv
tb/tb.sv
